### sv/ihex_pkg.sv
// ----------------------------------------------------------------------------
// Intel HEX loader package
// Shared codes, character constants and decode helpers for the loader.
// ----------------------------------------------------------------------------
package ihex_pkg;

  typedef enum logic [1:0] {
    RUN_AWAIT = 2'd0,
    RUN_IN    = 2'd1,
    RUN_DONE  = 2'd2,
    RUN_HALT  = 2'd3
  } run_e;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_OK    = 2'd1,
    KIND_END   = 2'd2,
    KIND_ERR   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_NO_COLON = 2'd1,
    ERR_CHECKSUM = 2'd2,
    ERR_BAD_HEX  = 2'd3
  } err_e;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  // Header bytes before the data: count, address high, address low, type.
  localparam int unsigned HDR_BYTES = 4;

  // Bit 4 set means the character is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 5'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 5'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 5'(c - 8'h57);
    end
    return v;
  endfunction

  // Space, or tab through carriage return.
  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

endpackage

### sv/ihex_if.sv
// ----------------------------------------------------------------------------
// Intel HEX loader channels
// Valid/ready channels for the character stream and for the result stream.
// ----------------------------------------------------------------------------
interface ihex_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface ihex_res_if #(
  parameter int unsigned ADDR_BITS = 16,
  parameter int unsigned LINE_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           out_kind;
  logic [ADDR_BITS-1:0] write_addr;
  logic [7:0]           write_data;
  logic [1:0]           err_code;
  logic [LINE_BITS-1:0] line_no;
  logic [ADDR_BITS:0]   end_addr;

  modport source (output valid, output out_kind, output write_addr, output write_data,
                  output err_code, output line_no, output end_addr, input ready);
  modport sink   (input valid, input out_kind, input write_addr, input write_data,
                  input err_code, input line_no, input end_addr, output ready);
endinterface

### sv/ihex_in_stage.sv
// ----------------------------------------------------------------------------
// Intel HEX loader input stage
// Registers one character and hands it to the parser when it may advance.
// ----------------------------------------------------------------------------
module ihex_in_stage
  import ihex_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ihex_char_if.sink   char_i,
  input  logic        advance_i,
  output logic        vld_o,
  output logic [7:0]  char_o
);

  logic       vld_q, vld_d;
  logic [7:0] char_q;
  logic       take;

  // The register may be refilled in the same cycle its item moves on.
  assign char_i.ready = !vld_q || advance_i;
  assign take         = char_i.valid && char_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (advance_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      char_q <= char_i.char_in;
    end
  end

  assign vld_o  = vld_q;
  assign char_o = char_q;

endmodule

### sv/ihex_parse.sv
// ----------------------------------------------------------------------------
// Intel HEX loader parser
// Record state and the decode of one character into at most one result.
// ----------------------------------------------------------------------------
module ihex_parse
  import ihex_pkg::*;
#(
  parameter int unsigned ADDR_BITS = 16,
  parameter int unsigned LINE_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           char_i,
  output logic                 res_vld_o,
  output kind_e                kind_o,
  output logic [ADDR_BITS-1:0] addr_o,
  output logic [7:0]           data_o,
  output err_e                 err_o,
  output logic [LINE_BITS-1:0] line_o,
  output logic [ADDR_BITS:0]   end_o
);

  localparam logic [ADDR_BITS:0] END_CAP = {1'b1, {ADDR_BITS{1'b0}}};

  run_e                 run_q, run_d;
  logic [9:0]           pos_q, pos_d;
  logic [7:0]           cnt_q, cnt_d;
  logic [ADDR_BITS-1:0] addr_q, addr_d;
  logic [3:0]           type_q, type_d;
  logic [7:0]           sum_q, sum_d;
  logic [3:0]           hi_q, hi_d;
  logic [LINE_BITS-1:0] line_q, line_d;
  logic [ADDR_BITS:0]   hend_q, hend_d;

  logic [4:0]           digit;
  logic [7:0]           byte_val;
  logic [8:0]           idx;
  logic [8:0]           data_idx;
  logic [ADDR_BITS+7:0] addr_hi_ext;
  logic [ADDR_BITS:0]   rec_end;

  assign digit       = hex_value(char_i);
  assign byte_val    = {hi_q, digit[3:0]};
  assign idx         = pos_q[9:1];
  assign data_idx    = idx - 9'(HDR_BYTES);
  assign addr_hi_ext = (ADDR_BITS + 8)'(byte_val) << 8;
  assign rec_end     = (ADDR_BITS + 1)'(addr_q) + (ADDR_BITS + 1)'(cnt_q);

  always_comb begin
    run_d     = run_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    addr_d    = addr_q;
    type_d    = type_q;
    sum_d     = sum_q;
    hi_d      = hi_q;
    line_d    = line_q;
    hend_d    = hend_q;
    res_vld_o = 1'b0;
    kind_o    = KIND_WRITE;
    addr_o    = '0;
    data_o    = '0;
    err_o     = ERR_NONE;
    end_o     = '0;

    if (step_i) begin
      unique case (run_q)
        RUN_AWAIT: begin
          if (is_blank(char_i)) begin
            run_d = RUN_AWAIT;
          end else if (char_i == CHAR_COLON) begin
            run_d = RUN_IN;
            pos_d = '0;
            sum_d = '0;
          end else begin
            run_d     = RUN_HALT;
            res_vld_o = 1'b1;
            kind_o    = KIND_ERR;
            err_o     = ERR_NO_COLON;
          end
        end
        RUN_IN: begin
          if (digit[4]) begin
            run_d     = RUN_HALT;
            res_vld_o = 1'b1;
            kind_o    = KIND_ERR;
            err_o     = ERR_BAD_HEX;
          end else if (!pos_q[0]) begin
            hi_d  = digit[3:0];
            pos_d = pos_q + 10'd1;
          end else begin
            pos_d = pos_q + 10'd1;
            sum_d = sum_q + byte_val;
            if (idx == 9'd0) begin
              cnt_d = byte_val;
            end else if (idx == 9'd1) begin
              addr_d = addr_hi_ext[ADDR_BITS-1:0];
            end else if (idx == 9'd2) begin
              addr_d = addr_q | ADDR_BITS'(byte_val);
            end else if (idx == 9'd3) begin
              type_d = byte_val[3:0];
            end else if (idx < 9'(HDR_BYTES) + 9'(cnt_q)) begin
              res_vld_o = 1'b1;
              kind_o    = KIND_WRITE;
              addr_o    = addr_q + ADDR_BITS'(data_idx);
              data_o    = byte_val;
            end else begin
              // Checksum byte: the running sum including it must be zero.
              res_vld_o = 1'b1;
              if (sum_d != 8'd0) begin
                run_d  = RUN_HALT;
                kind_o = KIND_ERR;
                err_o  = ERR_CHECKSUM;
              end else if (type_q != 4'd0) begin
                run_d  = RUN_DONE;
                kind_o = KIND_END;
                end_o  = hend_q;
              end else begin
                run_d  = RUN_AWAIT;
                kind_o = KIND_OK;
                line_d = line_q + LINE_BITS'(1);
                if (rec_end > END_CAP) begin
                  if (END_CAP > hend_q) begin
                    hend_d = END_CAP;
                  end
                end else if (rec_end > hend_q) begin
                  hend_d = rec_end;
                end
              end
            end
          end
        end
        RUN_DONE, RUN_HALT: begin
          run_d = run_q;
        end
        default: begin
          run_d = run_q;
        end
      endcase
    end
  end

  assign line_o = line_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= RUN_AWAIT;
      pos_q  <= '0;
      cnt_q  <= '0;
      addr_q <= '0;
      type_q <= '0;
      sum_q  <= '0;
      hi_q   <= '0;
      line_q <= '0;
      hend_q <= '0;
    end else begin
      run_q  <= run_d;
      pos_q  <= pos_d;
      cnt_q  <= cnt_d;
      addr_q <= addr_d;
      type_q <= type_d;
      sum_q  <= sum_d;
      hi_q   <= hi_d;
      line_q <= line_d;
      hend_q <= hend_d;
    end
  end

endmodule

### sv/intel_hex_record_loader.sv
// ----------------------------------------------------------------------------
// Intel HEX record loader
// Streams an Intel HEX file one character per item and issues byte writes,
// record completions, the final end result, or an error.
// ----------------------------------------------------------------------------
// Usage: char_i takes one ASCII character per item. res_o gives at most one
// result item per character: a data write with its address and byte, a
// record-ok, an end result carrying the highest end address, or an error.
// Characters that give no result (whitespace, ':', digits of the header)
// are consumed silently.
// A character reaches res_o through one input register and one result register.
// Throughput: one character per cycle while no result is held back by res_o.ready.
// While a result waits, the input register takes at most one more character.
// Stall: while res_o.ready is low and a result is held, the parser pauses
// and the input register fills, after which char_i.ready drops.
// Reset: all state clears and the loader waits for a ':'. After an end
// record or an error, further characters are taken and ignored until reset.
// ----------------------------------------------------------------------------
module intel_hex_record_loader
  import ihex_pkg::*;
#(
  parameter int unsigned ADDR_BITS = 16,
  parameter int unsigned LINE_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ihex_char_if.sink  char_i,
  ihex_res_if.source res_o
);

  logic                 in_vld;
  logic [7:0]           in_char;
  logic                 advance;
  logic                 res_vld;
  kind_e                res_kind;
  logic [ADDR_BITS-1:0] res_addr;
  logic [7:0]           res_data;
  err_e                 res_err;
  logic [LINE_BITS-1:0] res_line;
  logic [ADDR_BITS:0]   res_end;

  logic                 out_vld_q, out_vld_d;
  logic                 out_free;
  kind_e                out_kind_q;
  logic [ADDR_BITS-1:0] out_addr_q;
  logic [7:0]           out_data_q;
  err_e                 out_err_q;
  logic [LINE_BITS-1:0] out_line_q;
  logic [ADDR_BITS:0]   out_end_q;

  assign out_free = !out_vld_q || res_o.ready;
  assign advance  = in_vld && out_free;

  ihex_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .char_i    (char_i),
    .advance_i (advance),
    .vld_o     (in_vld),
    .char_o    (in_char)
  );

  ihex_parse #(
    .ADDR_BITS (ADDR_BITS),
    .LINE_BITS (LINE_BITS)
  ) u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .char_i    (in_char),
    .res_vld_o (res_vld),
    .kind_o    (res_kind),
    .addr_o    (res_addr),
    .data_o    (res_data),
    .err_o     (res_err),
    .line_o    (res_line),
    .end_o     (res_end)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_free) begin
      out_vld_d = advance && res_vld;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_vld) begin
      out_kind_q <= res_kind;
      out_addr_q <= res_addr;
      out_data_q <= res_data;
      out_err_q  <= res_err;
      out_line_q <= res_line;
      out_end_q  <= res_end;
    end
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.out_kind   = out_kind_q;
  assign res_o.write_addr = out_addr_q;
  assign res_o.write_data = out_data_q;
  assign res_o.err_code   = out_err_q;
  assign res_o.line_no    = out_line_q;
  assign res_o.end_addr   = out_end_q;

endmodule

### tb/sv/intel_hex_record_loader_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Intel HEX record loader checker
// Follows every accepted character and predicts the loader's result items.
// Each accepted result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module intel_hex_record_loader_checker
  import ihex_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ihex_char_if char_i,
  ihex_res_if  res_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    kind_e       kind;
    logic [15:0] addr;
    logic [7:0]  data;
    err_e        err;
    logic [15:0] line;
    logic [16:0] end_addr;
  } load_result_t;

  load_result_t expected_q[$];
  load_result_t want;
  bit           ok;
  int           fails = 0;

  // Parser state as the loader should hold it.
  run_e        status;
  logic [9:0]  digit_pos;
  logic [7:0]  byte_cnt;
  logic [15:0] rec_addr;
  logic [3:0]  type_lo;
  logic [7:0]  rec_sum;
  logic [3:0]  hi_digit;
  logic [15:0] rec_no;
  logic [16:0] top_end;

  // Bit 4 flags a character that is not a hex digit.
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return {1'b0, c[3:0]};
    if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) return {1'b0, c[3:0] + 4'd9};
    return 5'h10;
  endfunction

  function automatic bit field_ok(input string name, input logic [16:0] exp_v,
                                  input logic [16:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s expected %0d, actual %0d", name, exp_v, act_v);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic absorb_char(input logic [7:0] c);
    load_result_t r;
    logic [4:0]   d;
    logic [7:0]   b;
    int unsigned  idx;
    logic [16:0]  e;
    r = '0;
    r.line = rec_no;
    d = digit_of(c);
    case (status)
      RUN_AWAIT: begin
        if (c == CHAR_COLON) begin
          status = RUN_IN;
          digit_pos = '0;
          rec_sum = '0;
        end else if (!(c inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]})) begin
          status = RUN_HALT;
          r.kind = KIND_ERR;
          r.err = ERR_NO_COLON;
          expected_q.push_back(r);
        end
      end
      RUN_IN: begin
        if (d[4]) begin
          status = RUN_HALT;
          r.kind = KIND_ERR;
          r.err = ERR_BAD_HEX;
          expected_q.push_back(r);
        end else if (!digit_pos[0]) begin
          hi_digit = d[3:0];
          digit_pos = digit_pos + 10'd1;
        end else begin
          b = {hi_digit, d[3:0]};
          idx = digit_pos[9:1];
          digit_pos = digit_pos + 10'd1;
          rec_sum = rec_sum + b;
          if (idx == 0) begin
            byte_cnt = b;
          end else if (idx == 1) begin
            rec_addr = {b, 8'h00};
          end else if (idx == 2) begin
            rec_addr[7:0] = b;
          end else if (idx == 3) begin
            type_lo = b[3:0];
          end else if (idx < HDR_BYTES + int'(byte_cnt)) begin
            r.kind = KIND_WRITE;
            r.addr = rec_addr + 16'(idx - HDR_BYTES);
            r.data = b;
            expected_q.push_back(r);
          end else if (rec_sum != 8'h00) begin
            status = RUN_HALT;
            r.kind = KIND_ERR;
            r.err = ERR_CHECKSUM;
            expected_q.push_back(r);
          end else if (type_lo != 4'h0) begin
            // The end record's own span never moves the end address.
            status = RUN_DONE;
            r.kind = KIND_END;
            r.end_addr = top_end;
            expected_q.push_back(r);
          end else begin
            status = RUN_AWAIT;
            e = {1'b0, rec_addr} + 17'(byte_cnt);
            if (e > 17'h10000) e = 17'h10000;
            if (e > top_end) top_end = e;
            r.kind = KIND_OK;
            expected_q.push_back(r);
            rec_no = rec_no + 16'd1;
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status = RUN_AWAIT;
      digit_pos = '0;
      byte_cnt = '0;
      rec_addr = '0;
      type_lo = '0;
      rec_sum = '0;
      hi_digit = '0;
      rec_no = '0;
      top_end = '0;
      expected_q.delete();
      fail_count_o <= fails;
      pending_o <= 0;
    end else begin
      if (char_i.valid && char_i.ready) absorb_char(char_i.char_in);
      if (res_i.valid && res_i.ready) begin
        if (expected_q.size() == 0) begin
          $error("result item with none expected, out_kind %0d", res_i.out_kind);
          fails++;
        end else begin
          want = expected_q.pop_front();
          ok = field_ok("out_kind", want.kind, res_i.out_kind);
          ok &= field_ok("write_addr", want.addr, res_i.write_addr);
          ok &= field_ok("write_data", want.data, res_i.write_data);
          ok &= field_ok("err_code", want.err, res_i.err_code);
          ok &= field_ok("line_no", want.line, res_i.line_no);
          ok &= field_ok("end_addr", want.end_addr, res_i.end_addr);
          if (!ok) fails++;
        end
      end
      fail_count_o <= fails;
      pending_o <= expected_q.size();
    end
  end

endmodule

### tb/sv/intel_hex_record_loader_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Intel HEX record loader testbench
// Streams blanks and well-formed records with random content into the loader,
// then closes the file with an end record or one kind of error, and follows
// with characters that must be ignored. A separate checker compares results.
// ----------------------------------------------------------------------------
module intel_hex_record_loader_tb;
  import ihex_pkg::*;

  localparam int unsigned TEXT_CHARS  = 2000;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          chars_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned take_idle_pct = 0;
  logic [7:0]  record_text[$];

  ihex_char_if char_ch ();
  ihex_res_if #(.ADDR_BITS(16), .LINE_BITS(16)) res_ch ();

  intel_hex_record_loader dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .char_i (char_ch.sink),
    .res_o  (res_ch.source)
  );

  intel_hex_record_loader_checker load_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .char_i       (char_ch),
    .res_i        (res_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("intel_hex_record_loader_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99, 0) >= take_idle_pct);
  end

  // Valid stays high from one item to the next unless a gap is drawn.
  task automatic send_char(input logic [7:0] c);
    if (chars_sent < TEXT_CHARS / 3) begin
      send_idle_pct = 29;
      take_idle_pct <= 75;
    end else if (chars_sent < 2 * TEXT_CHARS / 3) begin
      send_idle_pct = 75;
      take_idle_pct <= 29;
    end else begin
      send_idle_pct = 0;
      take_idle_pct <= 0;
    end
    while ($urandom_range(99, 0) < send_idle_pct) begin
      char_ch.valid <= 1'b0;
      @(posedge clk);
    end
    char_ch.valid   <= 1'b1;
    char_ch.char_in <= c;
    @(posedge clk);
    while (!char_ch.ready) @(posedge clk);
    chars_sent++;
  endtask

  function automatic logic [7:0] digit_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(1, 0) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  // Builds the digit text of one record; a nonzero sum_err corrupts the checksum.
  task automatic make_record(input logic [7:0] n, input logic [15:0] a,
                             input logic [7:0] ty, input logic [7:0] sum_err);
    logic [7:0] bytes_q[$];
    logic [7:0] sum;
    bytes_q = {n, a[15:8], a[7:0], ty};
    for (int i = 0; i < int'(n); i++) bytes_q.push_back(8'($urandom));
    sum = '0;
    foreach (bytes_q[i]) sum += bytes_q[i];
    bytes_q.push_back((8'h00 - sum) ^ sum_err);
    record_text = {};
    foreach (bytes_q[i]) begin
      record_text.push_back(digit_char(bytes_q[i][7:4]));
      record_text.push_back(digit_char(bytes_q[i][3:0]));
    end
  endtask

  // Sends the colon and the digits in front of cut_at; a negative cut_at sends all.
  task automatic send_record(input int cut_at);
    send_char(CHAR_COLON);
    for (int i = 0; i < record_text.size() && i != cut_at; i++) send_char(record_text[i]);
  endtask

  task automatic random_record();
    int unsigned pick;
    logic [7:0]  n;
    logic [15:0] a;
    repeat ($urandom_range(2, 0)) begin
      if ($urandom_range(5, 0) == 5) send_char(CHAR_SPACE);
      else send_char(CHAR_TAB + 8'($urandom_range(4, 0)));
    end
    pick = $urandom_range(99, 0);
    if (pick < 10) n = 8'd0;
    else if (pick < 85) n = 8'($urandom_range(16, 1));
    else if (pick < 97) n = 8'($urandom_range(64, 17));
    else if (pick < 99) n = 8'($urandom_range(254, 65));
    else n = 8'd255;
    // Records near the top of memory wrap their writes and saturate the end address.
    if ($urandom_range(99, 0) < 15) a = 16'($urandom_range(16'hFFFF, 16'hFF00));
    else a = 16'($urandom);
    make_record(n, a, {4'($urandom), 4'h0}, 8'h00);
    send_record(-1);
  endtask

  initial begin
    logic [7:0]  c;
    logic [4:0]  v;
    int unsigned ending;
    char_ch.valid   <= 1'b0;
    char_ch.char_in <= 8'h00;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every blank character, then a record at the top of memory with a
    // nonzero high type digit.
    send_char(CHAR_SPACE);
    for (c = CHAR_TAB; c <= CHAR_CR; c++) send_char(c);
    make_record(8'd2, 16'hFFFF, 8'h10, 8'h00);
    send_record(-1);

    while (chars_sent < TEXT_CHARS) random_record();

    // Only one way of closing the file fits in a run, since the loader stops.
    ending = $urandom_range(9, 0);
    if (ending < 4) begin
      make_record(8'($urandom_range(8, 0)), 16'($urandom),
                  {4'($urandom), 4'($urandom_range(15, 1))}, 8'h00);
      send_record(-1);
    end else if (ending < 6) begin
      make_record(8'($urandom_range(8, 0)), 16'($urandom), {4'($urandom), 4'h0},
                  8'($urandom_range(255, 1)));
      send_record(-1);
    end else if (ending < 8) begin
      make_record(8'($urandom_range(8, 0)), 16'($urandom), {4'($urandom), 4'h0}, 8'h00);
      send_record($urandom_range(record_text.size() - 1, 0));
      do begin
        c = 8'($urandom);
        v = hex_value(c);
      end while (!v[4]);
      send_char(c);
    end else begin
      do c = 8'($urandom); while (c == CHAR_COLON || is_blank(c));
      send_char(c);
    end

    // The loader has stopped, so these are taken and ignored.
    repeat (24) send_char(8'($urandom));
    char_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("intel_hex_record_loader_tb OK");
    end else begin
      $display("intel_hex_record_loader_tb NOT OK");
    end
    $finish;
  end

endmodule
